/* src/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions for the fixed block pool allocator
// Widths, register indexes, request codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int MAX_FREE_ENTRIES = 1024;
  localparam int STACK_AW         = $clog2(MAX_FREE_ENTRIES);
  localparam int COUNT_W          = STACK_AW + 1;

  localparam int OFFSET_W    = 16;
  localparam int BUMP_W      = 17;
  localparam int BLOCK_W     = 13;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 17;
  localparam int OUT_TDATA_W = 24;

  localparam logic [BUMP_W-1:0]  AREA_LIMIT = 17'h10000;
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_FREE_ENTRIES);

  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_BYTES  = 8'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } ctrl_state_t;

endpackage

`default_nettype wire

/* src/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// fbpa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/fixed_block_pool_allocator_core.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool allocator
// Pops recently freed offsets from a LIFO free stack held in RAM, otherwise
// carves new blocks from a bump offset; frees push onto the stack.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                   Handshake
// s_*       in   tuser: func, tdata: free_offset           s_tvalid/s_tready
// m_*       out  tdata: granted, block_offset, status      m_tvalid/m_tready
// cfg_*     in   cfg_index, cfg_data                       cfg_valid/cfg_ready
//
// The result of a free, a carve or a failed allocate is loaded into the
// output register at the edge that accepts the request beat. An allocate
// served from the free stack first waits in ST_POP for the registered read
// of the stack RAM and takes no new request while it waits. A new request
// beat is taken while the block is not waiting on the RAM and the output
// register is empty or being drained in that cycle.
// Reset (rst, synchronous) empties the stack count, clears the bump offset and
// restores the register defaults; the stack RAM itself is not cleared.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_core (
  input  wire                                clk,
  input  wire                                rst,
  // Request channel.
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire                                s_tuser,   // [0] func
  input  wire [fbpa_pkg::OFFSET_W-1:0]       s_tdata,   // [15:0] free_offset
  // Result channel.
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // [0] granted, [16:1] block_offset, [17] area_full, [18] can_allocate,
  // [19] stack_overflow, [23:20] zero
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // Configuration write channel.
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fbpa_pkg::*;

  // Configuration registers.
  logic [BLOCK_W-1:0] block_bytes;
  logic [BUMP_W-1:0]  area_bytes;

  // Allocator state outside the stack RAM.
  logic [BUMP_W-1:0]  bump_offset, bump_offset_next;
  logic [COUNT_W-1:0] stack_count, stack_count_next;
  ctrl_state_t        state, state_next;

  logic                   m_tvalid_next;
  logic [OUT_TDATA_W-1:0] m_tdata_next;

  // Stack RAM controls.
  logic                ram_we, ram_re;
  logic [STACK_AW-1:0] ram_waddr, ram_raddr;
  logic [OFFSET_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;

  // Area bookkeeping. An area above the limit acts as the limit, and a bump
  // offset past the area leaves no uncarved space at all.
  logic [BUMP_W-1:0] area_eff;
  logic [BUMP_W:0]   carve_sum;
  logic [BUMP_W-1:0] bump_after_carve;
  logic [BUMP_W-1:0] uncarved_now, uncarved_carve;
  logic              full_now, full_carve;
  logic              stack_empty, stack_full;

  assign cfg_ready = 1'b1;

  assign area_eff         = (area_bytes > AREA_LIMIT) ? AREA_LIMIT : area_bytes;
  // The carve only happens when the block fits, so the sum stays in 17 bits.
  assign carve_sum        = {1'b0, bump_offset} + {{(BUMP_W + 1 - BLOCK_W){1'b0}}, block_bytes};
  assign bump_after_carve = carve_sum[BUMP_W-1:0];

  assign uncarved_now   = (area_eff > bump_offset) ? (area_eff - bump_offset) : '0;
  assign uncarved_carve = (area_eff > bump_after_carve) ? (area_eff - bump_after_carve) : '0;

  // A zero block size carves nothing, so the area always counts as full.
  assign full_now   = (block_bytes == '0) ||
                      (uncarved_now < {{(BUMP_W - BLOCK_W){1'b0}}, block_bytes});
  assign full_carve = (block_bytes == '0) ||
                      (uncarved_carve < {{(BUMP_W - BLOCK_W){1'b0}}, block_bytes});

  assign stack_empty = (stack_count == '0);
  assign stack_full  = (stack_count >= COUNT_FULL);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    bump_offset_next = bump_offset;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    ram_we           = 1'b0;
    ram_waddr        = stack_count[STACK_AW-1:0];
    ram_re           = 1'b0;
    ram_raddr        = stack_count[STACK_AW-1:0] - 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_tuser == FUNC_FREE) begin
            // Free: push unchecked; a full stack drops the push and flags it.
            m_tvalid_next = 1'b1;
            if (stack_full) begin
              m_tdata_next = {4'b0, 1'b1, 1'b1, full_now, {OFFSET_W{1'b0}}, 1'b1};
            end else begin
              ram_we           = 1'b1;
              stack_count_next = stack_count + 1'b1;
              m_tdata_next     = {4'b0, 1'b0, 1'b1, full_now, {OFFSET_W{1'b0}}, 1'b1};
            end
          end else if (!stack_empty) begin
            // Allocate from the stack: the offset returns from the RAM next cycle.
            ram_re           = 1'b1;
            stack_count_next = stack_count - 1'b1;
            state_next       = ST_POP;
          end else if (!full_now) begin
            // Allocate by carving at the bump offset; the stack is empty here.
            bump_offset_next = bump_after_carve;
            m_tvalid_next    = 1'b1;
            m_tdata_next     = {4'b0, 1'b0, !full_carve, full_carve,
                                bump_offset[OFFSET_W-1:0], 1'b1};
          end else begin
            // Nothing stacked and no room left to carve.
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, 1'b0, 1'b0, 1'b1, {OFFSET_W{1'b0}}, 1'b0};
          end
        end
      end
      ST_POP: begin
        // The output register was emptied when the pop was taken.
        m_tvalid_next = 1'b1;
        m_tdata_next  = {4'b0, 1'b0, (!stack_empty || !full_now), full_now,
                         ram_rdata, 1'b1};
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stack_count <= '0;
      bump_offset <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      bump_offset <= bump_offset_next;
      m_tvalid    <= m_tvalid_next;
    end
    m_tdata <= m_tdata_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_W'(8);
      area_bytes  <= AREA_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_BYTES: block_bytes <= cfg_data[BLOCK_W-1:0];
        REG_AREA_BYTES:  area_bytes  <= cfg_data[BUMP_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (MAX_FREE_ENTRIES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // While the RAM read is in flight nothing else may occupy the output.
  a_pop_output_empty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !m_tvalid)
    else $error("output register occupied during stack pop");

  // A pop from a nonempty stack always goes through the RAM wait state.
  a_pop_enters_wait : assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == FUNC_ALLOC && !stack_empty) |=> (state == ST_POP))
    else $error("stack pop did not wait for RAM data");

  // The stack count never passes the stack depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    stack_count <= COUNT_FULL)
    else $error("stack count beyond depth");

  // Carving never moves the bump offset past the area limit.
  a_bump_bound : assert property (@(posedge clk) disable iff (rst)
    bump_offset <= AREA_LIMIT)
    else $error("bump offset beyond area limit");

  // A dropped free leaves the count at the full depth.
  a_overflow_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == FUNC_FREE && stack_full) |=> (stack_count == COUNT_FULL))
    else $error("overflowing free changed the stack count");

endmodule

`default_nettype wire
